// ===== hdl/hashed_trie_transition_table_core_macros.svh =====
// assertion macros used by the trie table back end
`ifndef HASHED_TRIE_TRANSITION_TABLE_CORE_MACROS_SVH
`define HASHED_TRIE_TRANSITION_TABLE_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define HTT_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("trie table check failed");

// next-cycle implication, held off during reset
`define HTT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("trie table check failed");

`endif

// ===== hdl/htt_pkg.sv =====
package htt_pkg;

	localparam int OP_W     = 3;
	localparam int LETTER_W = 8;
	localparam int NODE_W   = 10;
	localparam int WLEN_W   = 16;
	localparam int CNT_W    = 32;
	localparam int ST_W     = 3;
	localparam int CFG_W    = 11;
	localparam int NUSED_W  = 11;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_END    = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_FILL   = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_CAPACITY  = 3'd1;
	localparam logic [ST_W-1:0] ST_IGNORED   = 3'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_RANGE     = 3'd4;

	// classified command between front and back
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic                oor;
		logic [LETTER_W-1:0] letter;
		logic [NODE_W-1:0]   node;
		logic [WLEN_W-1:0]   wlen;
		logic [CNT_W-1:0]    amount;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

endpackage

// ===== hdl/hashed_trie_transition_table_core.sv =====
// end word, add and read go through the finish count store to the output word; out-of-range
// and ignored ops go straight to it; lookup and insert find the bucket with the bit-serial
// index divider (node id bits + 8 steps) and walk its chain, which an insert skips once
// the word has left the trie; throughput: one command at a time, the next starts the cycle
// after a result word is loaded; fill root runs the search once per letter, up to 256;
// reset: async, active low, then a clearing pass over the bucket and finish count stores with s_tready low
module hashed_trie_transition_table_core #(
	parameter int NODE_LIMIT   = 1024,
	parameter int BUCKET_DEPTH = 1366,
	parameter int EDGE_DEPTH   = 1279
) (
	input  logic        clk,
	input  logic        arst_n,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // letter[7:0], node[17:8], word_length[33:18], amount[65:34]
	input  logic [7:0]  s_tuser,   // op[2:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // target_node[9:0], count[41:10], nodes_used[52:42]
	output logic [7:0]  m_tuser,   // status[2:0]
	// max_nodes register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);

	localparam int MW  = $clog2(NODE_LIMIT+1);
	localparam int BIW = $clog2(BUCKET_DEPTH);
	// reciprocal of 3 scaled by 2^20, exact for the 4*m range used here
	localparam int REC = 349526;
	localparam int PW  = MW + 2 + 21;

	logic [htt_pkg::CFG_W-1:0] cfg_q;
	logic [BIW:0]              b_q;
	logic [MW-1:0]             m_n;
	logic [PW-1:0]             prod;
	logic [PW-1:0]             b_raw;

	htt_pkg::push_t push;
	htt_pkg::cmd_t  q_head;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic           clear_done;

	assign cfg_ready = 1'b1;

	// capacity in use, clamped to 1..NODE_LIMIT, follows the register at once
	always_comb begin
		if (cfg_q == '0) begin
			m_n = MW'(1);
		end else if (32'(cfg_q) > NODE_LIMIT) begin
			m_n = MW'(NODE_LIMIT);
		end else begin
			m_n = MW'(cfg_q);
		end
		// bucket count floor(4m/3), clamped to the bucket store
		prod  = PW'({m_n, 2'b00}) * PW'(REC);
		b_raw = prod >> 20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= htt_pkg::CFG_W'(1024);
			b_q   <= (BIW+1)'(BUCKET_DEPTH);
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (b_raw > PW'(BUCKET_DEPTH)) begin
				b_q <= (BIW+1)'(BUCKET_DEPTH);
			end else if (b_raw == '0) begin
				b_q <= (BIW+1)'(1);
			end else begin
				b_q <= (BIW+1)'(b_raw);
			end
		end
	end

	// front: takes and classifies command words
	htt_front #(
		.NODE_LIMIT(NODE_LIMIT)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m        (m_n),
		.can_take (!q_full && clear_done),
		.push     (push)
	);

	// two-entry queue between front and back
	htt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.valid  (q_valid),
		.head   (q_head),
		.pop    (q_pop)
	);

	// back: hash, chain walk, edge and count stores, result register
	htt_back #(
		.NODE_LIMIT   (NODE_LIMIT),
		.BUCKET_DEPTH (BUCKET_DEPTH),
		.EDGE_DEPTH   (EDGE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.m          (m_n),
		.b          (b_q),
		.q_valid    (q_valid),
		.q_cmd      (q_head),
		.q_pop      (q_pop),
		.clear_done (clear_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== hdl/htt_front.sv =====
module htt_front #(
	parameter int NODE_LIMIT = 1024
) (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [71:0]                       s_tdata,  // letter, node, word_length, amount
	input  logic [7:0]                        s_tuser,  // op
	input  logic [$clog2(NODE_LIMIT+1)-1:0]   m,
	input  logic                              can_take,
	output htt_pkg::push_t                    push
);

	htt_pkg::cmd_t cmd;

	always_comb begin
		cmd.op     = s_tuser[2:0];
		cmd.letter = s_tdata[7:0];
		cmd.node   = s_tdata[17:8];
		cmd.wlen   = s_tdata[33:18];
		cmd.amount = s_tdata[65:34];
		// node id beyond the capacity in use
		cmd.oor    = 32'(s_tdata[17:8]) >= 32'(m);
	end

	assign s_tready  = can_take;
	assign push.push = s_tvalid && can_take;
	assign push.cmd  = cmd;

endmodule

// ===== hdl/htt_queue.sv =====
module htt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  htt_pkg::push_t push,
	output logic           full,
	output logic           valid,
	output htt_pkg::cmd_t  head,
	input  logic           pop
);

	htt_pkg::cmd_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    fill_q;

	assign full  = fill_q == 2'd2;
	assign valid = fill_q != 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push.push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push.push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push.push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/htt_back.sv =====
`include "hashed_trie_transition_table_core_macros.svh"

module htt_back #(
	parameter int NODE_LIMIT   = 1024,
	parameter int BUCKET_DEPTH = 1366,
	parameter int EDGE_DEPTH   = 1279
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(NODE_LIMIT+1)-1:0]     m,
	input  logic [$clog2(BUCKET_DEPTH):0]       b,
	input  logic                                q_valid,
	input  htt_pkg::cmd_t                       q_cmd,
	output logic                                q_pop,
	output logic                                clear_done,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [55:0]                         m_tdata,  // target_node, count, nodes_used
	output logic [7:0]                          m_tuser   // status
);

	localparam int NW      = $clog2(NODE_LIMIT);
	localparam int MW      = $clog2(NODE_LIMIT+1);
	localparam int BIW     = $clog2(BUCKET_DEPTH);
	localparam int EW      = $clog2(EDGE_DEPTH);
	localparam int EUW     = $clog2(EDGE_DEPTH+1);
	localparam int XW      = NW + 8;
	localparam int XCW     = $clog2(XW);
	localparam int CLR_LEN = (BUCKET_DEPTH > NODE_LIMIT) ? BUCKET_DEPTH : NODE_LIMIT;
	localparam int CW      = $clog2(CLR_LEN+1);
	localparam int NUSED_LOCAL = htt_pkg::NUSED_W;

	typedef struct packed {
		logic [NW-1:0]  src;
		logic [7:0]     letter;
		logic [NW-1:0]  tgt;
		logic [EUW-1:0] link;
	} edge_t;

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_MOD    = 13'b0000000000100,
		S_HEAD   = 13'b0000000001000,
		S_WALK0  = 13'b0000000010000,
		S_CHK    = 13'b0000000100000,
		S_RD1    = 13'b0000001000000,
		S_RD2    = 13'b0000010000000,
		S_EXEC   = 13'b0000100000000,
		S_FCRD   = 13'b0001000000000,
		S_FCWAIT = 13'b0010000000000,
		S_OUT    = 13'b0100000000000,
		S_SPARE  = 13'b1000000000000
	} state_t;

	state_t            state_q;
	htt_pkg::cmd_t     cmd_q;
	logic [CW-1:0]     clr_q;
	logic [NW-1:0]     walk_q;
	logic              sm_q;
	logic [15:0]       pos_q;
	logic              abort_q;
	logic [MW-1:0]     nfn_q;
	logic [EUW-1:0]    eu_q;
	logic [XW-1:0]     x_q;
	logic [BIW:0]      rem_q;
	logic [XCW-1:0]    mcnt_q;
	logic [NW-1:0]     src_q;
	logic [7:0]        let_q;
	logic [EUW-1:0]    e_q;
	logic [EUW-1:0]    head_q;
	logic [EW-1:0]     ei_q;
	logic              hit_q;
	logic [NW-1:0]     tgt_q;
	logic [NW-1:0]     fa_q;
	logic [2:0]        res_st_q;
	logic [NW-1:0]     res_tgt_q;
	logic [31:0]       res_cnt_q;
	logic              m_valid_q;
	logic [55:0]       m_data_q;
	logic [2:0]        m_user_q;

	logic [EUW-1:0]    bucket_mem [BUCKET_DEPTH];
	edge_t             edge_mem   [EDGE_DEPTH];
	logic [31:0]       fc_mem     [NODE_LIMIT];
	logic [EUW-1:0]    head_rd_q;
	edge_t             edge_rd_q;
	logic [31:0]       fc_rd_q;

	logic              bh_we;
	logic [BIW-1:0]    bh_wa;
	logic [EUW-1:0]    bh_wd;
	logic              ed_we;
	edge_t             ed_wd;
	logic              fc_we;
	logic [NW-1:0]     fc_wa;
	logic [31:0]       fc_wd;

	// remainder step of the bucket index divider
	logic [BIW:0]      mod_t;
	logic [BIW:0]      mod_n;
	assign mod_t = {rem_q[BIW-1:0], x_q[XW-1]};
	assign mod_n = (mod_t >= b) ? mod_t - b : mod_t;

	// hash key seed for the next search
	logic [NW-1:0]     ms_src;
	logic [7:0]        ms_let;
	logic [XW-1:0]     x_init;
	assign x_init = {ms_src, 8'h00} - XW'(ms_src) + XW'(ms_let);

	// insert decision
	logic [15:0]       rem_len;
	logic [MW-1:0]     free_n;
	logic              early_fail;
	logic              create_try;
	logic              create_fail;
	logic              do_create;
	logic [NW-1:0]     ins_walk;
	logic              edges_full;
	logic              fill_add;
	logic [32:0]       sum;
	logic [31:0]       sat;
	logic              out_load;

	assign edges_full  = eu_q >= EUW'(EDGE_DEPTH);
	assign rem_len     = (cmd_q.wlen > pos_q) ? cmd_q.wlen - pos_q : 16'd1;
	assign free_n      = (m > nfn_q) ? m - nfn_q : '0;
	assign early_fail  = sm_q && !hit_q && (32'(rem_len) > 32'(free_n));
	assign create_try  = !sm_q || (!hit_q && !early_fail);
	assign create_fail = create_try && ((nfn_q >= m) || edges_full);
	assign do_create   = create_try && !create_fail;
	assign ins_walk    = (sm_q && hit_q) ? tgt_q : (do_create ? NW'(nfn_q) : walk_q);
	assign fill_add    = !hit_q && !edges_full;
	assign out_load    = (state_q == S_OUT) && (!m_valid_q || m_tready);

	// saturating finish count update
	always_comb begin
		if (cmd_q.op == htt_pkg::OP_END) begin
			sum = {1'b0, fc_rd_q} + 33'd1;
		end else begin
			sum = {1'b0, fc_rd_q} + {1'b0, cmd_q.amount};
		end
		sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	end

	always_comb begin
		ms_src = '0;
		ms_let = let_q + 8'd1;
		if (state_q == S_IDLE) begin
			ms_let = q_cmd.letter;
			if (q_cmd.op == htt_pkg::OP_INSERT) begin
				ms_src = walk_q;
			end else if (q_cmd.op == htt_pkg::OP_LOOKUP) begin
				ms_src = NW'(q_cmd.node);
			end else if (q_cmd.op == htt_pkg::OP_FILL) begin
				ms_let = 8'h00;
			end
		end
	end

	always_comb begin
		bh_we = 1'b0;
		bh_wa = rem_q[BIW-1:0];
		bh_wd = eu_q + EUW'(1);
		ed_we = 1'b0;
		ed_wd.src    = walk_q;
		ed_wd.letter = let_q;
		ed_wd.tgt    = NW'(nfn_q);
		ed_wd.link   = head_q;
		fc_we = 1'b0;
		fc_wa = fa_q;
		fc_wd = sat;
		if (state_q == S_CLEAR) begin
			bh_wa = BIW'(clr_q);
			bh_wd = '0;
			bh_we = 32'(clr_q) < BUCKET_DEPTH;
			fc_wa = NW'(clr_q);
			fc_wd = '0;
			fc_we = 32'(clr_q) < NODE_LIMIT;
		end else if (state_q == S_EXEC) begin
			if (cmd_q.op == htt_pkg::OP_INSERT && do_create) begin
				bh_we = 1'b1;
				ed_we = 1'b1;
			end else if (cmd_q.op == htt_pkg::OP_FILL && fill_add) begin
				bh_we = 1'b1;
				ed_we = 1'b1;
				ed_wd.src = '0;
				ed_wd.tgt = '0;
			end
		end else if (state_q == S_FCWAIT) begin
			fc_we = cmd_q.op != htt_pkg::OP_READ;
		end
	end

	always_ff @(posedge clk) begin
		if (bh_we) begin
			bucket_mem[bh_wa] <= bh_wd;
		end
		head_rd_q <= bucket_mem[rem_q[BIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ed_we) begin
			edge_mem[eu_q[EW-1:0]] <= ed_wd;
		end
		edge_rd_q <= edge_mem[ei_q];
	end

	always_ff @(posedge clk) begin
		if (fc_we) begin
			fc_mem[fc_wa] <= fc_wd;
		end
		fc_rd_q <= fc_mem[fa_q];
	end

	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign clear_done = state_q != S_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			walk_q    <= '0;
			sm_q      <= 1'b1;
			pos_q     <= '0;
			abort_q   <= 1'b0;
			nfn_q     <= MW'(1);
			eu_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (32'(clr_q) == CLR_LEN - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q     <= q_cmd;
						res_st_q  <= htt_pkg::ST_OK;
						res_tgt_q <= '0;
						res_cnt_q <= '0;
						src_q     <= ms_src;
						let_q     <= ms_let;
						x_q       <= x_init;
						rem_q     <= '0;
						mcnt_q    <= XCW'(XW-1);
						state_q   <= S_OUT;
						priority case (q_cmd.op)
							htt_pkg::OP_INSERT: begin
								if (abort_q) begin
									res_st_q  <= htt_pkg::ST_IGNORED;
									res_tgt_q <= walk_q;
								end else begin
									state_q <= S_MOD;
								end
							end
							htt_pkg::OP_END: begin
								fa_q <= walk_q;
								if (abort_q) begin
									res_st_q <= htt_pkg::ST_IGNORED;
									walk_q   <= '0;
									sm_q     <= 1'b1;
									pos_q    <= '0;
									abort_q  <= 1'b0;
								end else begin
									state_q <= S_FCRD;
								end
							end
							htt_pkg::OP_LOOKUP: begin
								if (q_cmd.oor) begin
									res_st_q <= htt_pkg::ST_RANGE;
								end else begin
									state_q <= S_MOD;
								end
							end
							htt_pkg::OP_ADD, htt_pkg::OP_READ: begin
								fa_q <= NW'(q_cmd.node);
								if (q_cmd.oor) begin
									res_st_q <= htt_pkg::ST_RANGE;
								end else begin
									state_q <= S_FCRD;
								end
							end
							htt_pkg::OP_FILL: begin
								state_q <= S_MOD;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_MOD: begin
					rem_q  <= mod_n;
					x_q    <= {x_q[XW-2:0], 1'b0};
					mcnt_q <= mcnt_q - XCW'(1);
					if (mcnt_q == '0) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_WALK0;
				end
				S_WALK0: begin
					head_q <= head_rd_q;
					e_q    <= head_rd_q;
					hit_q  <= 1'b0;
					if (cmd_q.op == htt_pkg::OP_INSERT && !sm_q) begin
						state_q <= S_EXEC;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (e_q == '0 || e_q > eu_q) begin
						hit_q   <= 1'b0;
						state_q <= S_EXEC;
					end else begin
						ei_q    <= EW'(e_q - EUW'(1));
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					if (edge_rd_q.src == src_q && edge_rd_q.letter == let_q) begin
						hit_q   <= 1'b1;
						tgt_q   <= edge_rd_q.tgt;
						state_q <= S_EXEC;
					end else begin
						e_q     <= edge_rd_q.link;
						state_q <= S_CHK;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					priority case (cmd_q.op)
						htt_pkg::OP_INSERT: begin
							walk_q    <= ins_walk;
							res_tgt_q <= ins_walk;
							sm_q      <= sm_q && hit_q;
							if (early_fail || create_fail) begin
								abort_q  <= 1'b1;
								res_st_q <= htt_pkg::ST_CAPACITY;
							end
							if (do_create) begin
								nfn_q <= nfn_q + MW'(1);
								eu_q  <= eu_q + EUW'(1);
							end
							if (pos_q != 16'hFFFF) begin
								pos_q <= pos_q + 16'd1;
							end
						end
						htt_pkg::OP_LOOKUP: begin
							if (hit_q) begin
								res_tgt_q <= tgt_q;
							end else begin
								res_st_q <= htt_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
							// root fill, one letter per pass
							if (!hit_q && edges_full) begin
								res_st_q <= htt_pkg::ST_CAPACITY;
							end else begin
								if (fill_add) begin
									eu_q <= eu_q + EUW'(1);
								end
								if (let_q != 8'hFF) begin
									src_q   <= ms_src;
									let_q   <= ms_let;
									x_q     <= x_init;
									rem_q   <= '0;
									mcnt_q  <= XCW'(XW-1);
									state_q <= S_MOD;
								end
							end
						end
					endcase
				end
				S_FCRD: begin
					state_q <= S_FCWAIT;
				end
				S_FCWAIT: begin
					state_q <= S_OUT;
					if (cmd_q.op == htt_pkg::OP_READ) begin
						res_cnt_q <= fc_rd_q;
					end else begin
						res_cnt_q <= sat;
					end
					if (cmd_q.op == htt_pkg::OP_END) begin
						res_tgt_q <= walk_q;
						walk_q    <= '0;
						sm_q      <= 1'b1;
						pos_q     <= '0;
						abort_q   <= 1'b0;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_user_q  <= res_st_q;
						m_data_q  <= {3'b000, NUSED_LOCAL'(nfn_q), res_cnt_q, 10'(res_tgt_q)};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = {5'b00000, m_user_q};

	`HTT_ASSERT_NOW(a_pop_idle, clk, arst_n, q_pop, state_q == S_IDLE && q_valid)
	`HTT_ASSERT_NOW(a_edges_bound, clk, arst_n, 1'b1, eu_q <= EUW'(EDGE_DEPTH))
	`HTT_ASSERT_NOW(a_nodes_bound, clk, arst_n, 1'b1, nfn_q <= MW'(NODE_LIMIT) && nfn_q != '0)
	`HTT_ASSERT_NEXT(a_out_load, clk, arst_n, out_load, m_valid_q && state_q == S_IDLE)

endmodule
